// ----- sv/first_fit_block_allocator_core_defines.svh -----
// Assertion macros shared by the allocator checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FFBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ----- sv/ffba_pkg.sv -----
// Types, codes and constants of the first-fit block allocator.
// No dependencies; the interfaces, the core and the checker import this package.
package ffba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF   = 64;
  localparam int unsigned HEADER_BYTES_DEF = 32;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned SIZE_W    = 27;
  localparam int unsigned CNT_OUT_W = 7;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [SIZE_W-1:0] REQUEST_CAP     = 27'd100000000;
  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST  = 32'd16777216;
  localparam logic [SIZE_W-1:0] MAX_REQUEST_RST = 27'd100000000;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SIZE  = 2'd1,
    ST_HEAP  = 2'd2,
    ST_TABLE = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAP_LIMIT  = 1'b0,
    CFG_MAX_REQUEST = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]    result_address;
    status_e              status;
    logic [CNT_OUT_W-1:0] free_count;
    logic [ADDR_W-1:0]    free_total;
    logic [CNT_OUT_W-1:0] allocated_blocks;
    logic [ADDR_W-1:0]    allocated_bytes;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    wdata;
  } cfg_t;

endpackage

// ----- sv/ffba_if.sv -----
// Valid/ready channel interfaces for requests, responses and configuration writes.
// Depends on ffba_pkg for the payload types.
interface ffba_req_if;
  import ffba_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ffba_rsp_if;
  import ffba_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ffba_cfg_if;
  import ffba_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/first_fit_block_allocator_core.sv -----
// First-fit block allocator core: sequencer, block table memory and running totals.
// Depends on ffba_pkg and the channel interfaces in ffba_if.sv.
//
// The block takes one request at a time. A request whose size is rejected, a
// free of address zero, or an unused operation code has its response presented
// in the cycle after it is accepted. Every other request walks the block table
// through a single read port, one entry per cycle, then goes to a decide step;
// a reallocate that moves its block next returns the old entry to the free
// pool, and then the response is presented. The response is held in a register
// until it is taken, and the next request can be accepted in the cycle after that.
// The configuration port is always ready and writes take effect at once.
module first_fit_block_allocator_core #(
  parameter int unsigned MaxBlocks   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned HeaderBytes = ffba_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ffba_req_if.sink    req_i,
  ffba_rsp_if.source  rsp_o,
  ffba_cfg_if.sink    cfg_i
);
  import ffba_pkg::*;

  localparam int unsigned IdxW = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int unsigned CntW = $clog2(MaxBlocks + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FREE_OLD,
    S_RESP
  } state_e;

  // Block table.
  logic [ADDR_W-1:0] base_mem [MaxBlocks];
  logic [SIZE_W-1:0] size_mem [MaxBlocks];
  logic              free_mem [MaxBlocks];

  state_e            state_q;
  logic [1:0]        op_q;
  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] result_q;
  status_e           status_q;

  logic [ADDR_W-1:0] heap_limit_q;
  logic [SIZE_W-1:0] max_req_q;

  logic [CntW-1:0]   blk_cnt_q;
  logic [CntW-1:0]   free_cnt_q;
  logic [ADDR_W-1:0] heap_top_q;
  logic [ADDR_W-1:0] free_sum_q;
  logic [ADDR_W-1:0] table_bytes_q;

  // Scan pointer and the entry whose read data is in rd_*_q.
  logic [CntW-1:0]   ptr_q;
  logic              chk_valid_q;
  logic [IdxW-1:0]   chk_idx_q;
  logic [ADDR_W-1:0] rd_base_q;
  logic [SIZE_W-1:0] rd_size_q;
  logic              rd_free_q;

  logic              fit_found_q;
  logic [IdxW-1:0]   fit_idx_q;
  logic [ADDR_W-1:0] fit_base_q;
  logic [SIZE_W-1:0] fit_size_q;
  logic              find_found_q;
  logic [IdxW-1:0]   find_idx_q;
  logic              find_free_q;
  logic [SIZE_W-1:0] find_size_q;

  logic              size_ok;
  logic              rd_en;
  logic              fit_hit;
  logic              find_hit;
  logic              old_live;
  logic              keep_old;
  logic              alloc_path;
  logic              table_full;
  logic [ADDR_W+1:0] heap_end;
  logic              heap_over;
  logic              app_ok;
  logic              app_we;
  logic              flag_we;
  logic [IdxW-1:0]   flag_idx;
  logic              flag_val;

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign size_ok = (req_i.data.request_size != '0) &&
                   (req_i.data.request_size <= max_req_q) &&
                   (req_i.data.request_size <= REQUEST_CAP);

  assign rd_en = (state_q == S_SCAN) && (ptr_q < blk_cnt_q);

  // Per-entry checks on the registered table read.
  assign fit_hit  = rd_free_q && (rd_size_q >= size_q);
  assign find_hit = (op_q != OP_ALLOC) && (addr_q != '0) &&
                    (({1'b0, rd_base_q} + (ADDR_W+1)'(HeaderBytes)) == {1'b0, addr_q});

  always_comb begin
    old_live   = find_found_q && !find_free_q;
    keep_old   = (op_q == OP_REALLOC) && old_live && (find_size_q >= size_q);
    alloc_path = (op_q == OP_ALLOC) || ((op_q == OP_REALLOC) && !keep_old);
    table_full = (blk_cnt_q == CntW'(MaxBlocks));
    heap_end   = {2'b00, heap_top_q} + (ADDR_W+2)'(HeaderBytes) +
                 (ADDR_W+2)'(size_q);
    heap_over  = heap_end > {2'b00, heap_limit_q};
    app_ok     = alloc_path && !fit_found_q && !table_full && !heap_over;
  end

  // Table write control: one write per array and cycle.
  always_comb begin
    app_we   = 1'b0;
    flag_we  = 1'b0;
    flag_idx = find_idx_q;
    flag_val = 1'b1;
    case (state_q)
      S_DECIDE: begin
        if (op_q == OP_FREE) begin
          flag_we = old_live;
        end else if (alloc_path && fit_found_q) begin
          flag_we  = 1'b1;
          flag_idx = fit_idx_q;
          flag_val = 1'b0;
        end else if (app_ok) begin
          app_we   = 1'b1;
          flag_we  = 1'b1;
          flag_idx = IdxW'(blk_cnt_q);
          flag_val = 1'b0;
        end
      end
      S_FREE_OLD: begin
        flag_we = 1'b1;
      end
      default: begin
        flag_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (app_we) begin
      base_mem[IdxW'(blk_cnt_q)] <= heap_top_q;
      size_mem[IdxW'(blk_cnt_q)] <= size_q;
    end
    if (flag_we) begin
      free_mem[flag_idx] <= flag_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_base_q <= base_mem[IdxW'(ptr_q)];
      rd_size_q <= size_mem[IdxW'(ptr_q)];
      rd_free_q <= free_mem[IdxW'(ptr_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      op_q          <= '0;
      size_q        <= '0;
      addr_q        <= '0;
      result_q      <= '0;
      status_q      <= ST_OK;
      heap_limit_q  <= HEAP_LIMIT_RST;
      max_req_q     <= MAX_REQUEST_RST;
      blk_cnt_q     <= '0;
      free_cnt_q    <= '0;
      heap_top_q    <= '0;
      free_sum_q    <= '0;
      table_bytes_q <= '0;
      ptr_q         <= '0;
      chk_valid_q   <= 1'b0;
      chk_idx_q     <= '0;
      fit_found_q   <= 1'b0;
      fit_idx_q     <= '0;
      fit_base_q    <= '0;
      fit_size_q    <= '0;
      find_found_q  <= 1'b0;
      find_idx_q    <= '0;
      find_free_q   <= 1'b0;
      find_size_q   <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_reg_e'(cfg_i.data.index))
          CFG_HEAP_LIMIT:  heap_limit_q <= cfg_i.data.wdata;
          CFG_MAX_REQUEST: max_req_q    <= cfg_i.data.wdata[SIZE_W-1:0];
          default:         heap_limit_q <= heap_limit_q;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            op_q         <= req_i.data.operation;
            size_q       <= req_i.data.request_size;
            addr_q       <= req_i.data.block_address;
            result_q     <= '0;
            status_q     <= ST_OK;
            ptr_q        <= '0;
            chk_valid_q  <= 1'b0;
            fit_found_q  <= 1'b0;
            find_found_q <= 1'b0;
            case (op_e'(req_i.data.operation))
              OP_ALLOC, OP_REALLOC: begin
                if (size_ok) begin
                  state_q <= S_SCAN;
                end else begin
                  status_q <= ST_SIZE;
                  state_q  <= S_RESP;
                end
              end
              OP_FREE: begin
                state_q <= (req_i.data.block_address != '0) ? S_SCAN : S_RESP;
              end
              default: begin
                state_q <= S_RESP;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (chk_valid_q) begin
            if (!fit_found_q && fit_hit) begin
              fit_found_q <= 1'b1;
              fit_idx_q   <= chk_idx_q;
              fit_base_q  <= rd_base_q;
              fit_size_q  <= rd_size_q;
            end
            if (!find_found_q && find_hit) begin
              find_found_q <= 1'b1;
              find_idx_q   <= chk_idx_q;
              find_free_q  <= rd_free_q;
              find_size_q  <= rd_size_q;
            end
          end
          if (ptr_q < blk_cnt_q) begin
            ptr_q       <= ptr_q + 1'b1;
            chk_valid_q <= 1'b1;
            chk_idx_q   <= IdxW'(ptr_q);
          end else begin
            chk_valid_q <= 1'b0;
            if (!chk_valid_q) begin
              state_q <= S_DECIDE;
            end
          end
        end

        S_DECIDE: begin
          state_q <= S_RESP;
          if (op_q == OP_FREE) begin
            if (old_live) begin
              free_cnt_q <= free_cnt_q + 1'b1;
              free_sum_q <= free_sum_q + ADDR_W'(find_size_q);
            end
          end else if (keep_old) begin
            result_q <= addr_q;
          end else if (fit_found_q) begin
            free_cnt_q <= free_cnt_q - 1'b1;
            free_sum_q <= free_sum_q - ADDR_W'(fit_size_q);
            result_q   <= fit_base_q + ADDR_W'(HeaderBytes);
            if ((op_q == OP_REALLOC) && old_live) begin
              state_q <= S_FREE_OLD;
            end
          end else if (table_full) begin
            status_q <= ST_TABLE;
          end else if (heap_over) begin
            status_q <= ST_HEAP;
          end else begin
            blk_cnt_q     <= blk_cnt_q + 1'b1;
            table_bytes_q <= table_bytes_q + ADDR_W'(size_q);
            heap_top_q    <= heap_end[ADDR_W-1:0];
            result_q      <= heap_top_q + ADDR_W'(HeaderBytes);
            if ((op_q == OP_REALLOC) && old_live) begin
              state_q <= S_FREE_OLD;
            end
          end
        end

        S_FREE_OLD: begin
          // The moved block's old entry goes back to the free pool.
          free_cnt_q <= free_cnt_q + 1'b1;
          free_sum_q <= free_sum_q + ADDR_W'(find_size_q);
          state_q    <= S_RESP;
        end

        S_RESP: begin
          if (rsp_o.ready) begin
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid                  = (state_q == S_RESP);
  assign rsp_o.data.result_address    = result_q;
  assign rsp_o.data.status            = status_q;
  assign rsp_o.data.free_count        = CNT_OUT_W'(free_cnt_q);
  assign rsp_o.data.free_total        = free_sum_q;
  assign rsp_o.data.allocated_blocks  = CNT_OUT_W'(blk_cnt_q);
  assign rsp_o.data.allocated_bytes   = table_bytes_q;

endmodule

// ----- sv/ffba_checker.sv -----
// Port-level checks of the first-fit block allocator and their bind to the core.
// Depends on ffba_pkg and first_fit_block_allocator_core_defines.svh.
`include "first_fit_block_allocator_core_defines.svh"

module ffba_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_i,
  input logic           rsp_valid_i,
  input logic           rsp_ready_i,
  input ffba_pkg::rsp_t rsp_data_i
);
  import ffba_pkg::*;

  // A request keeps the block busy for at least the following cycle.
  `FFBA_ASSERT_NEXT(a_busy_after_req, req_valid_i && req_ready_i, !req_ready_i)

  // No new request is taken while a response is pending.
  `FFBA_ASSERT_NOW(a_no_req_during_rsp, rsp_valid_i, !req_ready_i)

  // A failed request never grants an address.
  `FFBA_ASSERT_NOW(a_fail_no_addr, rsp_valid_i && (rsp_data_i.status != ST_OK),
                   rsp_data_i.result_address == '0)

  // Free blocks are a subset of the table.
  `FFBA_ASSERT_NOW(a_free_le_alloc, rsp_valid_i,
                   rsp_data_i.free_count <= rsp_data_i.allocated_blocks)

  // A stalled response holds.
  `FFBA_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i,
                    rsp_valid_i && $stable(rsp_data_i))

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);
